@@ hdl/egsv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsv_pkg
// Shared types and register indexes for the signature verify unit.
// ----------------------------------------------------------------------------
package egsv_pkg;

    localparam int unsigned REG_IDX_BITS = 2;
    localparam int unsigned REG_DATA_BITS = 32;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_MODULUS_P    = 2'd0,
        REG_GENERATOR_G  = 2'd1,
        REG_PUBLIC_KEY_Y = 2'd2,
        REG_COMMIT_R     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] sig_word;
        logic [7:0]  hash_byte;
        logic        last_item;
    } in_beat_t;

    typedef struct packed {
        logic item_ok;
        logic all_ok;
        logic is_last;
    } out_beat_t;

    // Request and response between the sequencer and the modular multiplier.
    typedef struct packed {
        logic start;
    } mul_ctrl_t;

    typedef struct packed {
        logic done;
        logic busy;
    } mul_stat_t;

endpackage

@@ hdl/egsv_modmul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsv_modmul
// Iterative modular multiplier: one bit of the multiplier per cycle,
// interleaved with reduction, so no wide product or divider is needed.
// ----------------------------------------------------------------------------
module egsv_modmul #(
    parameter int unsigned MOD_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  egsv_pkg::mul_ctrl_t       ctrl,
    input  logic [MOD_BITS-1:0]       op_a,
    input  logic [MOD_BITS-1:0]       op_b,
    input  logic [MOD_BITS-1:0]       modulus,
    output egsv_pkg::mul_stat_t       stat,
    output logic [MOD_BITS-1:0]       product
);
    import egsv_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(MOD_BITS + 1);

    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] mult_reg, mult_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [MOD_BITS+1:0] dbl;
    logic [MOD_BITS+1:0] dbl_red;
    logic [MOD_BITS+1:0] add;

    // Shift-and-add step: acc = 2*acc (+ a) mod p, with operands below p.
    always_comb begin
        dbl      = {1'b0, acc_reg, 1'b0};
        dbl_red  = (dbl >= {2'b00, modulus}) ? dbl - {2'b00, modulus} : dbl;
        add      = dbl_red + (mult_reg[MOD_BITS-1] ? {2'b00, op_a} : '0);
        if (add >= {2'b00, modulus}) begin
            add = add - {2'b00, modulus};
        end
        acc_next  = acc_reg;
        mult_next = mult_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            acc_next  = '0;
            mult_next = op_b;
            cnt_next  = CNT_BITS'(MOD_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next  = add[MOD_BITS-1:0];
            mult_next = {mult_reg[MOD_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg  <= acc_next;
        mult_reg <= mult_next;
    end

    assign product   = acc_reg;
    assign stat.done = done_reg;
    assign stat.busy = busy_reg;

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> !stat.busy) else $error("done while busy");
    a_busy_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !ctrl.start |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("count did not step");
    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done && modulus >= MOD_BITS'(2) && $stable(modulus) |-> product < modulus)
        else $error("product not reduced");
`endif

endmodule

@@ hdl/elgamal_byte_signature_verify_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgamal_byte_signature_verify_unit
// Checks (y^r)(r^s) == g^h mod p for each signature beat, with a running
// all-match verdict that closes on the beat marked last.
// ----------------------------------------------------------------------------
// Usage:
//   Write p, g, y and r through cfg_we/cfg_index/cfg_data while idle.
//   Each input beat (s_valid/s_ready) carries s, h and a last flag; exactly
//   one result beat (m_valid/m_ready) follows with item_ok, all_ok, is_last.
// Work:
//   One shared bit-serial modular multiplier does all the work. Operand
//   reduction takes 3 products, y^r and r^s take at most 2 products per
//   exponent bit (MOD_BITS bits each), g^h at most 2 per bit of h (8),
//   plus one final product: at most (4*MOD_BITS + 20) products. A multiply
//   for a zero exponent bit is skipped. The block takes one beat at a time;
//   s_ready is low while it works, in the hold state after the result is
//   raised, and while that result waits for m_ready.
// Reset:
//   Registers return to p = 3, g = y = r = 0 and the running verdict to 1.
// Stall:
//   A finished result is held in the output register until m_ready; no new
//   input beat is accepted until that result is taken or is being taken.
// ----------------------------------------------------------------------------
module elgamal_byte_signature_verify_unit #(
    parameter int unsigned MOD_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [egsv_pkg::REG_IDX_BITS-1:0]     cfg_index,
    input  logic [egsv_pkg::REG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  egsv_pkg::in_beat_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output egsv_pkg::out_beat_t                   m_data
);
    import egsv_pkg::*;

    localparam int unsigned EXP_CNT_BITS = $clog2(MOD_BITS + 1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_RED    = 10'b0000000010,
        ST_EXP    = 10'b0000000100,
        ST_MUL    = 10'b0000001000,
        ST_SQR    = 10'b0000010000,
        ST_NEXT   = 10'b0000100000,
        ST_FINAL  = 10'b0001000000,
        ST_WAIT_F = 10'b0010000000,
        ST_DONE   = 10'b0100000000,
        ST_HOLD   = 10'b1000000000
    } state_t;

    // Configuration registers
    logic [31:0] p_reg, g_reg, y_reg, r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg <= 32'd3;
            g_reg <= '0;
            y_reg <= '0;
            r_reg <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODULUS_P:    p_reg <= cfg_data;
                REG_GENERATOR_G:  g_reg <= cfg_data;
                REG_PUBLIC_KEY_Y: y_reg <= cfg_data;
                REG_COMMIT_R:     r_reg <= cfg_data;
                default:          p_reg <= p_reg;
            endcase
        end
    end

    logic [MOD_BITS-1:0] p_m;
    assign p_m = p_reg[MOD_BITS-1:0];

    state_t              state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;     // 0: y^r, 1: r^s, 2: g^h
    logic [1:0]          red_reg, red_next;         // base reduction index
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] sq_reg, sq_next;
    logic [MOD_BITS-1:0] exp_reg, exp_next;
    logic [EXP_CNT_BITS-1:0] ecnt_reg, ecnt_next;
    logic [MOD_BITS-1:0] yr_reg, yr_next;           // reduced bases
    logic [MOD_BITS-1:0] rr_reg, rr_next;
    logic [MOD_BITS-1:0] gr_reg, gr_next;
    logic [MOD_BITS-1:0] a1_reg, a1_next;
    logic [MOD_BITS-1:0] a2_reg, a2_next;
    logic [MOD_BITS-1:0] s_reg;
    logic [7:0]          h_reg;
    logic                last_reg;
    logic                run_reg, run_next;
    logic                mv_reg, mv_next;
    out_beat_t           out_reg, out_next;
    logic                ok;
    logic                busy_start;
    logic                one_m;

    mul_ctrl_t           mctrl;
    mul_stat_t           mstat;
    logic [MOD_BITS-1:0] mop_a, mop_b, mprod;

    egsv_modmul #(.MOD_BITS(MOD_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mctrl),
        .op_a    (mop_a),
        .op_b    (mop_b),
        .modulus (p_m),
        .stat    (mstat),
        .product (mprod)
    );

    assign busy_start = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE) && !(mv_reg && !m_ready);
    // 1 mod p: p >= 2 here, so 1 stays 1.
    assign one_m      = 1'b1;

    // Sequencer over the shared multiplier.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        red_next   = red_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        exp_next   = exp_reg;
        ecnt_next  = ecnt_reg;
        yr_next    = yr_reg;
        rr_next    = rr_reg;
        gr_next    = gr_reg;
        a1_next    = a1_reg;
        a2_next    = a2_reg;
        run_next   = run_reg;
        mv_next    = mv_reg && !m_ready;
        out_next   = out_reg;
        mctrl      = '0;
        mop_a      = '0;
        mop_b      = '0;
        ok         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (busy_start) begin
                    red_next   = 2'd0;
                    state_next = (p_m >= MOD_BITS'(2)) ? ST_RED : ST_DONE;
                    if (p_m < MOD_BITS'(2)) begin
                        a1_next = '0;
                        a2_next = MOD_BITS'(1);
                    end
                end
            end
            ST_RED: begin
                // x mod p as 1*x mod p: x is fed as the multiplier bits, so the
                // step works through x one bit at a time, always below p.
                mop_a = MOD_BITS'(1);
                unique case (red_reg)
                    2'd0:    mop_b = y_reg[MOD_BITS-1:0];
                    2'd1:    mop_b = r_reg[MOD_BITS-1:0];
                    default: mop_b = g_reg[MOD_BITS-1:0];
                endcase
                if (!mstat.busy && !mstat.done) begin
                    mctrl.start = 1'b1;
                end
                if (mstat.done) begin
                    unique case (red_reg)
                        2'd0:    yr_next = mprod;
                        2'd1:    rr_next = mprod;
                        default: gr_next = mprod;
                    endcase
                    red_next = red_reg + 2'd1;
                    if (red_reg == 2'd2) begin
                        phase_next = 2'd0;
                        state_next = ST_EXP;
                    end
                end
            end
            ST_EXP: begin
                // Load one exponentiation.
                acc_next = MOD_BITS'(one_m);
                unique case (phase_reg)
                    2'd0: begin
                        sq_next   = yr_reg;
                        exp_next  = r_reg[MOD_BITS-1:0];
                        ecnt_next = EXP_CNT_BITS'(MOD_BITS);
                    end
                    2'd1: begin
                        sq_next   = rr_reg;
                        exp_next  = s_reg;
                        ecnt_next = EXP_CNT_BITS'(MOD_BITS);
                    end
                    default: begin
                        sq_next   = gr_reg;
                        exp_next  = {{(MOD_BITS-8){1'b0}}, h_reg};
                        ecnt_next = EXP_CNT_BITS'(8);
                    end
                endcase
                state_next = ST_MUL;
            end
            ST_MUL: begin
                mop_a = acc_reg;
                mop_b = sq_reg;
                if (!exp_reg[0]) begin
                    state_next = ST_SQR;
                end else begin
                    if (!mstat.busy && !mstat.done) begin
                        mctrl.start = 1'b1;
                    end
                    if (mstat.done) begin
                        acc_next   = mprod;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                mop_a = sq_reg;
                mop_b = sq_reg;
                if (!mstat.busy && !mstat.done) begin
                    mctrl.start = 1'b1;
                end
                if (mstat.done) begin
                    sq_next    = mprod;
                    exp_next   = exp_reg >> 1;
                    ecnt_next  = ecnt_reg - 1'b1;
                    state_next = (ecnt_reg == EXP_CNT_BITS'(1)) ? ST_NEXT : ST_MUL;
                end
            end
            ST_NEXT: begin
                unique case (phase_reg)
                    2'd0: begin
                        a1_next    = acc_reg;
                        phase_next = 2'd1;
                        state_next = ST_EXP;
                    end
                    2'd1: begin
                        a2_next    = acc_reg;
                        phase_next = 2'd2;
                        state_next = ST_EXP;
                    end
                    default: begin
                        // acc holds g^h; keep it in sq for the compare.
                        sq_next    = acc_reg;
                        state_next = ST_FINAL;
                    end
                endcase
            end
            ST_FINAL: begin
                mop_a = a1_reg;
                mop_b = a2_reg;
                if (!mstat.busy && !mstat.done) begin
                    mctrl.start = 1'b1;
                end
                if (mstat.done) begin
                    a1_next    = mprod;
                    a2_next    = sq_reg;
                    state_next = ST_WAIT_F;
                end
            end
            ST_WAIT_F: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Output register is free here: s_ready required it.
                ok = (p_m >= MOD_BITS'(2)) && (a1_reg == a2_reg);
                out_next.item_ok = ok;
                out_next.all_ok  = run_reg && ok;
                out_next.is_last = last_reg;
                run_next         = last_reg ? 1'b1 : (run_reg && ok);
                mv_next          = 1'b1;
                state_next       = ST_HOLD;
            end
            ST_HOLD: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            run_reg   <= 1'b1;
            mv_reg    <= 1'b0;
            phase_reg <= '0;
            red_reg   <= '0;
            ecnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            run_reg   <= run_next;
            mv_reg    <= mv_next;
            phase_reg <= phase_next;
            red_reg   <= red_next;
            ecnt_reg  <= ecnt_next;
        end
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        exp_reg <= exp_next;
        yr_reg  <= yr_next;
        rr_reg  <= rr_next;
        gr_reg  <= gr_next;
        a1_reg  <= a1_next;
        a2_reg  <= a2_next;
        out_reg <= out_next;
        if (busy_start) begin
            s_reg    <= s_data.sig_word[MOD_BITS-1:0];
            h_reg    <= s_data.hash_byte;
            last_reg <= s_data.last_item;
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready) else $error("ready while busy");
    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |=> m_valid) else $error("result not raised");
    a_last_resets_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && last_reg |=> run_reg) else $error("verdict not cleared");
    a_all_implies_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.all_ok |-> m_data.item_ok) else $error("all_ok without item_ok");
`endif

endmodule
